### hdl/bfv_pkg.sv
// Shared types and constants for the border feather vignette.
package bfv_pkg;

    // Field widths fixed by the pixel format.
    localparam int POS_W   = 7;
    localparam int SIDE_W  = 8;
    localparam int STEP_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int DIST_W  = 8;
    localparam int Q16_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // 1.0 in Q1.16 and the smoothstep constant 3.0 in Q2.16.
    localparam logic [Q16_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0]      THREE_Q16 = 18'h30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_COLUMN_STEP  = 2'd2,
        CFG_ROW_STEP     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
    } pixel_out_t;

endpackage

### hdl/bfv_axis.sv
// Per-axis border distance, ramp and smoothstep over four pipeline stages.
module bfv_axis (
    input  logic                       aclk,
    input  logic [3:0]                 stage_en,
    input  logic [bfv_pkg::POS_W-1:0]  pos,
    input  logic [bfv_pkg::SIDE_W-1:0] side,
    input  logic [bfv_pkg::STEP_W-1:0] step,
    output logic [bfv_pkg::Q16_W-1:0]  axis_value
);
    import bfv_pkg::*;

    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [Q16_W-1:0]   ramp_reg, ramp_next;
    logic [32:0]        ramp_sq_reg, ramp_sq_next;
    logic [17:0]        cubic_k_reg, cubic_k_next;
    logic [Q16_W-1:0]   smooth_reg, smooth_next;

    logic [7:0]         near_dist;
    logic [8:0]         far_dist;
    logic [23:0]        ramp_prod;
    logic [50:0]        smooth_sum;

    // Stage 1: half-sample distance to the nearer border.
    always_comb begin
        near_dist = {pos, 1'b1};
        far_dist  = {side, 1'b0} - {1'b0, pos, 1'b1};
        if ({1'b0, pos} >= side) begin
            dist_next = '0;
        end else if ({1'b0, near_dist} < far_dist) begin
            dist_next = near_dist;
        end else begin
            dist_next = far_dist[7:0];
        end
    end

    // Stage 2: ramp, saturated at one.
    always_comb begin
        ramp_prod = {8'd0, step} * {16'd0, dist_reg};
        if (ramp_prod > {7'd0, ONE_Q16}) begin
            ramp_next = ONE_Q16;
        end else begin
            ramp_next = ramp_prod[Q16_W-1:0];
        end
    end

    // Stage 3: square of the ramp and the (3 - 2t) factor.
    always_comb begin
        ramp_sq_next = {16'd0, ramp_reg} * {16'd0, ramp_reg};
        cubic_k_next = THREE_Q16 - {ramp_reg, 1'b0};
    end

    // Stage 4: final product, rounded half up back to Q1.16.
    always_comb begin
        smooth_sum  = {18'd0, ramp_sq_reg} * {33'd0, cubic_k_reg} + 51'h0_8000_0000;
        smooth_next = smooth_sum[48:32];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dist_reg <= dist_next;
        end
        if (stage_en[1]) begin
            ramp_reg <= ramp_next;
        end
        if (stage_en[2]) begin
            ramp_sq_reg <= ramp_sq_next;
            cubic_k_reg <= cubic_k_next;
        end
        if (stage_en[3]) begin
            smooth_reg <= smooth_next;
        end
    end

    assign axis_value = smooth_reg;

endmodule

### hdl/bfv_scale.sv
// Fade computation and per-channel scaling over two pipeline stages.
module bfv_scale (
    input  logic                      aclk,
    input  logic [1:0]                stage_en,
    input  logic [bfv_pkg::Q16_W-1:0] col_value,
    input  logic [bfv_pkg::Q16_W-1:0] row_value,
    input  bfv_pkg::pixel_in_t        pix_in,
    output bfv_pkg::pixel_out_t       pix_out
);
    import bfv_pkg::*;

    logic [Q16_W-1:0]  fade_reg, fade_next;
    pixel_in_t         pix_reg;
    pixel_out_t        out_reg, out_next;

    logic [33:0]       mask_sum;

    // Fade is one minus the rounded product of the two axis values.
    always_comb begin
        mask_sum  = {17'd0, col_value} * {17'd0, row_value} + 34'h8000;
        fade_next = ONE_Q16 - mask_sum[32:16];
    end

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] chan,
                                                     input logic [Q16_W-1:0] fade);
        logic [24:0] prod;
        prod = {17'd0, chan} * {8'd0, fade} + 25'h8000;
        return prod[23:16];
    endfunction

    always_comb begin
        out_next.red_out   = scale_chan(pix_reg.red_in, fade_reg);
        out_next.green_out = scale_chan(pix_reg.green_in, fade_reg);
        out_next.blue_out  = scale_chan(pix_reg.blue_in, fade_reg);
        out_next.alpha_out = scale_chan(pix_reg.alpha_in, fade_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            fade_reg <= fade_next;
            pix_reg  <= pix_in;
        end
        if (stage_en[1]) begin
            out_reg <= out_next;
        end
    end

    assign pix_out = out_reg;

endmodule

### hdl/border_feather_vignette.sv
// Border feather vignette top level: config registers, valid pipeline, datapath.
// An accepted input transaction passes the axis stages, the fade stage and the output stage to m_data.
// Throughput is one pixel per cycle while the output is not stalled; stage one finds the distance.
// Stalls collapse bubbles: a stage loads whenever it is empty or the stage after it is loading.
// Reset (aresetn low, synchronous) empties the pipeline and restores the config defaults.
module border_feather_vignette #(
    parameter int MAX_SIDE = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [bfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfv_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  bfv_pkg::pixel_in_t            s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output bfv_pkg::pixel_out_t           m_data
);
    import bfv_pkg::*;

    // Four axis stages followed by the fade stage and the output stage.
    localparam int NUM_STAGES = 6;
    localparam int AXIS_STAGES = 4;

    // The side registers are 8 bits wide, so a cap above 255 never bites.
    localparam logic [SIDE_W-1:0] SIDE_CAP = (MAX_SIDE > 255) ? 8'hFF : 8'(MAX_SIDE);

    // Configuration registers. The user must see that they are only written while
    // the pipeline is empty, so the datapath reads them directly; the block does not enforce it.
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [STEP_W-1:0] col_step_reg;
    logic [STEP_W-1:0] row_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 8'd128;
            height_reg   <= 8'd128;
            col_step_reg <= 16'd2048;
            row_step_reg <= 16'd2048;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_wr_data[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_wr_data[SIDE_W-1:0];
                CFG_COLUMN_STEP:  col_step_reg <= cfg_wr_data[STEP_W-1:0];
                CFG_ROW_STEP:     row_step_reg <= cfg_wr_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective image sides, saturated at the largest supported side.
    logic [SIDE_W-1:0] col_side;
    logic [SIDE_W-1:0] row_side;

    assign col_side = (width_reg > SIDE_CAP) ? SIDE_CAP : width_reg;
    assign row_side = (height_reg > SIDE_CAP) ? SIDE_CAP : height_reg;

    // Valid bits travel alongside the data. A stage loads when it is empty or
    // when the stage after it is loading too, so a stall at the output only
    // backs up as far as the nearest bubble.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // The pixel channels ride along the axis stages until the fade is ready.
    pixel_in_t pix_reg [AXIS_STAGES];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pix_reg[0] <= s_data;
        end
        for (int i = 1; i < AXIS_STAGES; i++) begin
            if (stage_en[i]) begin
                pix_reg[i] <= pix_reg[i-1];
            end
        end
    end

    // One smoothstep unit per axis; both share the stage enables.
    logic [Q16_W-1:0] col_value;
    logic [Q16_W-1:0] row_value;

    bfv_axis u_col_axis (
        .aclk       (aclk),
        .stage_en   (stage_en[AXIS_STAGES-1:0]),
        .pos        (s_data.column),
        .side       (col_side),
        .step       (col_step_reg),
        .axis_value (col_value)
    );

    bfv_axis u_row_axis (
        .aclk       (aclk),
        .stage_en   (stage_en[AXIS_STAGES-1:0]),
        .pos        (s_data.row),
        .side       (row_side),
        .step       (row_step_reg),
        .axis_value (row_value)
    );

    // Fade and channel scaling; the last stage is the output register.
    bfv_scale u_scale (
        .aclk      (aclk),
        .stage_en  (stage_en[NUM_STAGES-1:AXIS_STAGES]),
        .col_value (col_value),
        .row_value (row_value),
        .pix_in    (pix_reg[AXIS_STAGES-1]),
        .pix_out   (m_data)
    );

    // An empty output stage means nothing can hold up the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NUM_STAGES-1] |-> s_ready)
        else $error("input stalled while the output stage is empty");

    // A stalled output only blocks the input when every stage is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && s_ready) |-> !(&valid_reg))
        else $error("input accepted into a full pipeline");

    // A result can only appear when the fade stage held a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(valid_reg[NUM_STAGES-2]))
        else $error("result appeared without a transaction behind it");

    // Axis values are Q1.16 and never exceed one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[AXIS_STAGES-1] |-> (col_value <= ONE_Q16 && row_value <= ONE_Q16))
        else $error("axis value above one");

endmodule
